// File: rtl/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement block.
// No dependencies; imported by lrupr_cell and lru_page_replacement_top.
`default_nettype none

package lrupr_pkg;

  // fixed field widths of the request and result
  localparam int unsigned PAGE_IN_W = 16;
  localparam int unsigned FIDX_W    = 6;
  localparam int unsigned EVPG_W    = 16;
  localparam int unsigned FAULT_W   = 32;

  // per-frame age counter
  localparam int unsigned     AGE_W   = 16;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // search record flags travelling down the chain
  typedef struct packed {
    logic tok;          // record is live in this stage
    logic hit_found;    // a valid frame matched the page
    logic empty_found;  // an empty frame was seen
    logic max_found;    // max-age candidate taken
  } lrupr_flags_t;

  // broadcast update applied to every cell at the end of a search
  typedef struct packed {
    logic en;    // apply ageing this cycle
    logic load;  // miss: load page into the selected frame
  } lrupr_upd_t;

endpackage

`default_nettype wire

// File: rtl/lru_page_replacement_top.sv
// Top level of the LRU page replacement block: chain of frame cells plus result logic.
// Depends on lrupr_pkg and lrupr_cell.
//
// Usage:
//   A page reference is taken on page_i at a rising edge where start is high
//   and busy is low. busy then stays high until the result is issued.
//   The reference walks the row of NUM_FRAMES frame cells, one cell per cycle,
//   each cell folding its frame into a search record (first hit, first empty
//   frame, oldest frame). At the end of the row the frame is chosen and all
//   cells update their ages together.
//   The record is registered in each cell in turn, and the result registers
//   take it as it leaves the row; result_valid_o is high for exactly one cycle
//   after that, carrying hit_o, frame_index_o, evicted_valid_o, evicted_page_o and
//   fault_total_o. busy drops in that same cycle, so a new reference can be
//   taken while the result is shown, but not before the previous one has left
//   the row of cells.
//   The receiver has no way to stall; results must be sampled on the strobe.
//   Reset empties all frames, clears ages and the fault count.
`default_nettype none

module lru_page_replacement_top #(
  parameter int unsigned NUM_FRAMES = 4,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               start,
  output logic                              busy,
  input  wire  [lrupr_pkg::PAGE_IN_W-1:0]   page_i,
  output logic                              result_valid_o,
  output logic                              hit_o,
  output logic [lrupr_pkg::FIDX_W-1:0]      frame_index_o,
  output logic                              evicted_valid_o,
  output logic [lrupr_pkg::EVPG_W-1:0]      evicted_page_o,
  output logic [lrupr_pkg::FAULT_W-1:0]     fault_total_o
);
  import lrupr_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_FRAMES);

  // chain wiring: element k is the record entering cell k, element NUM_FRAMES leaves the row
  lrupr_flags_t            ch_flags    [NUM_FRAMES+1];
  logic [PAGE_BITS-1:0]    ch_page     [NUM_FRAMES+1];
  logic [IDX_W-1:0]        ch_hit_idx  [NUM_FRAMES+1];
  logic [IDX_W-1:0]        ch_empty_idx[NUM_FRAMES+1];
  logic [IDX_W-1:0]        ch_max_idx  [NUM_FRAMES+1];
  logic [AGE_W-1:0]        ch_max_age  [NUM_FRAMES+1];
  logic [PAGE_BITS-1:0]    ch_max_page [NUM_FRAMES+1];
  logic [NUM_FRAMES-1:0]   tok_vec;

  lrupr_upd_t              upd;
  logic [IDX_W-1:0]        upd_slot;
  logic                    accept;

  logic                    busy_q, busy_d;
  logic [FAULT_W-1:0]      fault_q, fault_d;
  logic                    rv_q;
  logic                    hit_q;
  logic [FIDX_W-1:0]       fidx_q;
  logic                    evv_q;
  logic [EVPG_W-1:0]       evpg_q;

  logic                    last_tok, miss, ev_valid;

  assign accept = start && !busy_q;

  // inject a fresh search record into the head of the row
  always_comb begin
    ch_flags[0]     = '0;
    ch_flags[0].tok = accept;
    ch_page[0]      = PAGE_BITS'(page_i);
    ch_hit_idx[0]   = '0;
    ch_empty_idx[0] = '0;
    ch_max_idx[0]   = '0;
    ch_max_age[0]   = '0;
    ch_max_page[0]  = '0;
  end

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    lrupr_cell #(
      .IDX_W   (IDX_W),
      .PAGE_W  (PAGE_BITS),
      .CELL_IDX(g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .flags_i    (ch_flags[g]),
      .page_i     (ch_page[g]),
      .hit_idx_i  (ch_hit_idx[g]),
      .empty_idx_i(ch_empty_idx[g]),
      .max_idx_i  (ch_max_idx[g]),
      .max_age_i  (ch_max_age[g]),
      .max_page_i (ch_max_page[g]),
      .flags_o    (ch_flags[g+1]),
      .page_o     (ch_page[g+1]),
      .hit_idx_o  (ch_hit_idx[g+1]),
      .empty_idx_o(ch_empty_idx[g+1]),
      .max_idx_o  (ch_max_idx[g+1]),
      .max_age_o  (ch_max_age[g+1]),
      .max_page_o (ch_max_page[g+1]),
      .upd_i      (upd),
      .upd_slot_i (upd_slot),
      .upd_page_i (ch_page[NUM_FRAMES])
    );
    assign tok_vec[g] = ch_flags[g+1].tok;
  end

  // frame choice once the record leaves the row
  always_comb begin
    last_tok = ch_flags[NUM_FRAMES].tok;
    miss     = !ch_flags[NUM_FRAMES].hit_found;
    ev_valid = miss && !ch_flags[NUM_FRAMES].empty_found;
    if (!miss) begin
      upd_slot = ch_hit_idx[NUM_FRAMES];
    end else if (!ev_valid) begin
      upd_slot = ch_empty_idx[NUM_FRAMES];
    end else begin
      upd_slot = ch_max_idx[NUM_FRAMES];
    end
    upd.en   = last_tok;
    upd.load = miss;
  end

  // busy and saturating fault count
  always_comb begin
    busy_d  = busy_q;
    fault_d = fault_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (last_tok) begin
      busy_d = 1'b0;
    end
    if (last_tok && miss && (fault_q != FAULT_MAX)) begin
      fault_d = fault_q + FAULT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      fault_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      fault_q <= fault_d;
      rv_q    <= last_tok;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (last_tok) begin
      hit_q  <= !miss;
      fidx_q <= FIDX_W'(upd_slot);
      evv_q  <= ev_valid;
      evpg_q <= ev_valid ? EVPG_W'(ch_max_page[NUM_FRAMES]) : '0;
    end
  end

  assign busy            = busy_q;
  assign result_valid_o  = rv_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = fidx_q;
  assign evicted_valid_o = evv_q;
  assign evicted_page_o  = evpg_q;
  assign fault_total_o   = fault_q;

  // checks
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one request in the cell chain");

  a_busy_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after accepting a request");

  a_result_after_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_tok |=> (result_valid_o && !busy))
    else $error("result not issued after search completed");

  a_tok_needs_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_vec != '0) |-> busy_q)
    else $error("search active while not busy");

  a_evict_is_miss : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && evicted_valid_o) |-> !hit_o)
    else $error("eviction reported on a hit");

endmodule

`default_nettype wire

// File: rtl/lrupr_cell.sv
// One frame of the table: page, valid bit, age, plus one stage of the search chain.
// Depends on lrupr_pkg.
`default_nettype none

module lrupr_cell #(
  parameter int unsigned IDX_W    = 2,
  parameter int unsigned PAGE_W   = 16,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // search record from the left neighbour
  input  wire lrupr_pkg::lrupr_flags_t flags_i,
  input  wire  [PAGE_W-1:0]          page_i,
  input  wire  [IDX_W-1:0]           hit_idx_i,
  input  wire  [IDX_W-1:0]           empty_idx_i,
  input  wire  [IDX_W-1:0]           max_idx_i,
  input  wire  [lrupr_pkg::AGE_W-1:0] max_age_i,
  input  wire  [PAGE_W-1:0]          max_page_i,
  // search record to the right neighbour
  output lrupr_pkg::lrupr_flags_t    flags_o,
  output logic [PAGE_W-1:0]          page_o,
  output logic [IDX_W-1:0]           hit_idx_o,
  output logic [IDX_W-1:0]           empty_idx_o,
  output logic [IDX_W-1:0]           max_idx_o,
  output logic [lrupr_pkg::AGE_W-1:0] max_age_o,
  output logic [PAGE_W-1:0]          max_page_o,
  // broadcast update
  input  wire lrupr_pkg::lrupr_upd_t upd_i,
  input  wire  [IDX_W-1:0]           upd_slot_i,
  input  wire  [PAGE_W-1:0]          upd_page_i
);
  import lrupr_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  // frame state
  logic              valid_q, valid_d;
  logic [PAGE_W-1:0] fpage_q, fpage_d;
  logic [AGE_W-1:0]  age_q, age_d;

  // search stage registers
  lrupr_flags_t      flags_q, flags_d;
  logic [PAGE_W-1:0] page_q;
  logic [IDX_W-1:0]  hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]  empty_idx_q, empty_idx_d;
  logic [IDX_W-1:0]  max_idx_q, max_idx_d;
  logic [AGE_W-1:0]  max_age_q, max_age_d;
  logic [PAGE_W-1:0] max_page_q, max_page_d;

  logic take_hit, take_empty, take_max;

  // search step: fold this frame into the travelling record
  always_comb begin
    take_hit   = !flags_i.hit_found && valid_q && (fpage_q == page_i);
    take_empty = !flags_i.empty_found && !valid_q;
    take_max   = !flags_i.max_found || (age_q > max_age_i);

    flags_d.tok         = flags_i.tok;
    flags_d.hit_found   = flags_i.hit_found | take_hit;
    flags_d.empty_found = flags_i.empty_found | take_empty;
    flags_d.max_found   = 1'b1;

    hit_idx_d   = take_hit   ? MY_IDX : hit_idx_i;
    empty_idx_d = take_empty ? MY_IDX : empty_idx_i;
    max_idx_d   = take_max   ? MY_IDX : max_idx_i;
    max_age_d   = take_max   ? age_q  : max_age_i;
    max_page_d  = take_max   ? fpage_q : max_page_i;
  end

  // frame update: selected frame loads/clears, the others age
  always_comb begin
    valid_d = valid_q;
    fpage_d = fpage_q;
    age_d   = age_q;
    if (upd_i.en) begin
      if (upd_slot_i == MY_IDX) begin
        age_d = '0;
        if (upd_i.load) begin
          valid_d = 1'b1;
          fpage_d = upd_page_i;
        end
      end else if (valid_q && (age_q != AGE_MAX)) begin
        age_d = age_q + AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fpage_q <= '0;
      age_q   <= '0;
      flags_q <= '0;
    end else begin
      valid_q <= valid_d;
      fpage_q <= fpage_d;
      age_q   <= age_d;
      flags_q <= flags_d;
    end
  end

  // record payload moves only with a live token
  always_ff @(posedge clk_i) begin
    if (flags_i.tok) begin
      page_q      <= page_i;
      hit_idx_q   <= hit_idx_d;
      empty_idx_q <= empty_idx_d;
      max_idx_q   <= max_idx_d;
      max_age_q   <= max_age_d;
      max_page_q  <= max_page_d;
    end
  end

  assign flags_o     = flags_q;
  assign page_o      = page_q;
  assign hit_idx_o   = hit_idx_q;
  assign empty_idx_o = empty_idx_q;
  assign max_idx_o   = max_idx_q;
  assign max_age_o   = max_age_q;
  assign max_page_o  = max_page_q;

endmodule

`default_nettype wire

// File: bench/lru_lookup_scoreboard.sv
// Scoreboard for lru_page_replacement_top: predicts every page lookup and checks each result.
// Depends on lrupr_pkg for field widths and saturation limits.
`default_nettype none

module lru_lookup_scoreboard #(
  parameter int unsigned NUM_FRAMES = 4,
  parameter int unsigned PAGE_BITS  = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire                              busy_i,
  input  wire  [lrupr_pkg::PAGE_IN_W-1:0]  page_i,
  input  wire                              result_valid_i,
  input  wire                              hit_i,
  input  wire  [lrupr_pkg::FIDX_W-1:0]     frame_index_i,
  input  wire                              evicted_valid_i,
  input  wire  [lrupr_pkg::EVPG_W-1:0]     evicted_page_i,
  input  wire  [lrupr_pkg::FAULT_W-1:0]    fault_total_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      outstanding_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import lrupr_pkg::*;

  localparam logic [31:0] PAGE_MASK = (PAGE_BITS >= 32) ? '1 : ((32'd1 << PAGE_BITS) - 32'd1);

  typedef struct packed {
    logic               hit;
    logic [FIDX_W-1:0]  frame;
    logic               ev_valid;
    logic [EVPG_W-1:0]  ev_page;
    logic [FAULT_W-1:0] faults;
  } lookup_result_t;

  // shadow copy of the frame table
  logic [31:0]        page_table [NUM_FRAMES];
  logic               frame_live [NUM_FRAMES];
  logic [AGE_W-1:0]   frame_age  [NUM_FRAMES];
  logic [FAULT_W-1:0] faults_seen;

  lookup_result_t pending_results [$];

  // one lookup: find the page, else fill the first empty frame, else replace the oldest
  task automatic predict_lookup(input logic [PAGE_IN_W-1:0] page, output lookup_result_t res);
    logic [31:0] pg;
    int          slot;
    logic        found;
    logic        have_empty;
    pg         = 32'(page) & PAGE_MASK;
    slot       = 0;
    found      = 1'b0;
    have_empty = 1'b0;
    res        = '0;
    for (int f = 0; f < NUM_FRAMES; f++) begin
      if (!found && frame_live[f] && page_table[f] == pg) begin
        found = 1'b1;
        slot  = f;
      end
    end
    if (!found) begin
      for (int f = 0; f < NUM_FRAMES; f++) begin
        if (!have_empty && !frame_live[f]) begin
          have_empty = 1'b1;
          slot       = f;
        end
      end
      // all full: strictly greater keeps the lowest index on ties
      if (!have_empty) begin
        slot = 0;
        for (int f = 1; f < NUM_FRAMES; f++) begin
          if (frame_age[f] > frame_age[slot]) slot = f;
        end
        res.ev_valid = 1'b1;
        res.ev_page  = page_table[slot][EVPG_W-1:0];
      end
      page_table[slot] = pg;
      frame_live[slot] = 1'b1;
      if (faults_seen != FAULT_MAX) faults_seen = faults_seen + 1'b1;
    end
    // touched frame goes young, other live frames age with saturation
    for (int f = 0; f < NUM_FRAMES; f++) begin
      if (f == slot) begin
        frame_age[f] = '0;
      end else if (frame_live[f] && frame_age[f] != AGE_MAX) begin
        frame_age[f] = frame_age[f] + 1'b1;
      end
    end
    res.hit    = found;
    res.frame  = slot[FIDX_W-1:0];
    res.faults = faults_seen;
  endtask

  // results are checked before a new request is taken: both may fall on one edge
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    lookup_result_t want;
    lookup_result_t got;
    if (!rst_ni) begin
      for (int f = 0; f < NUM_FRAMES; f++) begin
        page_table[f] = '0;
        frame_live[f] = 1'b0;
        frame_age[f]  = '0;
      end
      faults_seen = '0;
      pending_results.delete();
      fail_count_o  = 0;
      outstanding_o = 0;
    end else begin
      if (result_valid_i) begin
        got = '{hit_i, frame_index_i, evicted_valid_i, evicted_page_i, fault_total_i};
        if (pending_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: result with no request outstanding: hit=%0b frame=%0d", $realtime,
                     got.hit, got.frame);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: mismatch", $realtime);
              $display("  expected hit=%0b frame=%0d evicted=%0b page=%h faults=%0d",
                       want.hit, want.frame, want.ev_valid, want.ev_page, want.faults);
              $display("  actual   hit=%0b frame=%0d evicted=%0b page=%h faults=%0d",
                       got.hit, got.frame, got.ev_valid, got.ev_page, got.faults);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_lookup(page_i, want);
        pending_results.push_back(want);
      end
      outstanding_o = pending_results.size();
    end
  end

endmodule

`default_nettype wire

// File: bench/tb_lru_page_replacement_top.sv
// Testbench top for lru_page_replacement_top: drives page requests and gives the verdict.
// Depends on lrupr_pkg, the block itself and lru_lookup_scoreboard.
`default_nettype none

module tb_lru_page_replacement_top;

  timeunit 1ns;
  timeprecision 1ps;

  import lrupr_pkg::*;

  localparam int unsigned NUM_FRAMES  = 4;
  localparam int unsigned PAGE_BITS   = 16;
  localparam int unsigned KEEP_HITS   = 8;
  localparam int unsigned RANDOM_REFS = 500;
  localparam int unsigned CALM_REFS   = 100;
  localparam int unsigned POOL_SIZE   = 6;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [PAGE_IN_W-1:0] page;
  logic                 result_valid;
  logic                 hit;
  logic [FIDX_W-1:0]    frame_index;
  logic                 evicted_valid;
  logic [EVPG_W-1:0]    evicted_page;
  logic [FAULT_W-1:0]   fault_total;
  int unsigned          fail_count;
  int unsigned          outstanding;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_page_replacement_top #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .page_i          (page),
    .result_valid_o  (result_valid),
    .hit_o           (hit),
    .frame_index_o   (frame_index),
    .evicted_valid_o (evicted_valid),
    .evicted_page_o  (evicted_page),
    .fault_total_o   (fault_total)
  );

  lru_lookup_scoreboard #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) i_scoreboard (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start_i         (start),
    .busy_i          (busy),
    .page_i          (page),
    .result_valid_i  (result_valid),
    .hit_i           (hit),
    .frame_index_i   (frame_index),
    .evicted_valid_i (evicted_valid),
    .evicted_page_i  (evicted_page),
    .fault_total_i   (fault_total),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding)
  );

  // hold a request until the block takes it, then maybe idle for a burst
  task automatic send_ref(input logic [PAGE_IN_W-1:0] pg, input bit allow_gap);
    start <= 1'b1;
    page  <= pg;
    do @(posedge clk); while (busy);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // stop sending until every outstanding result has been seen
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // directed: empty frames, field extremes, hits, evictions and re-use of a victim
  logic [PAGE_IN_W-1:0] directed_refs [20] = '{
    16'h0000, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h1234, 16'h0000,
    16'h8000, 16'h0001, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h0001, 16'h1234, 16'hFFFE,
    16'hFFFF, 16'h8000, 16'h0001, 16'h0000
  };

  initial begin : stimulus
    logic [PAGE_IN_W-1:0] page_pool [POOL_SIZE];
    logic [PAGE_IN_W-1:0] pg;
    start = 1'b0;
    page  = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_refs[i]) send_ref(directed_refs[i], 1'b1);

    // load four fresh pages, keep one of them young with repeated hits,
    // then further misses replace the oldest frames and an older surviving page hits again
    send_ref(16'h0101, 1'b0);
    send_ref(16'h0202, 1'b0);
    send_ref(16'h0303, 1'b0);
    send_ref(16'h0404, 1'b0);
    repeat (KEEP_HITS) send_ref(16'h0202, 1'b0);
    send_ref(16'h0505, 1'b0);
    send_ref(16'h0606, 1'b0);
    send_ref(16'h0404, 1'b0);
    send_ref(16'h0707, 1'b0);
    drain();

    // random: mostly a small working set so hits and evictions mix, some wide pages
    foreach (page_pool[i]) page_pool[i] = 16'($urandom);
    for (int i = 0; i < RANDOM_REFS; i++) begin
      if ($urandom_range(0, 19) == 0) page_pool[$urandom_range(0, POOL_SIZE - 1)] = 16'($urandom);
      if ($urandom_range(0, 99) < 85) pg = page_pool[$urandom_range(0, POOL_SIZE - 1)];
      else pg = 16'($urandom);
      send_ref(pg, i < RANDOM_REFS - CALM_REFS);
      if (i == RANDOM_REFS / 2) drain();
    end

    drain();
    repeat (2 * (NUM_FRAMES + 1)) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, well above the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
